[design/gpx_pkg.sv]
// Package for the GPIO expander register block: request codes, register
// indexes, controller state and command types. No dependencies.
`default_nettype none

package gpx_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned PinIdxW = 3;
    localparam int unsigned ModeW   = 2;
    localparam int unsigned RegIdxW = 2;

    localparam logic [ModeW-1:0] MODE_WR_START = 2'd0;
    localparam logic [ModeW-1:0] MODE_WR_BYTE  = 2'd1;
    localparam logic [ModeW-1:0] MODE_RD_REQ   = 2'd2;
    localparam logic [ModeW-1:0] MODE_PIN_CHG  = 2'd3;

    localparam logic [RegIdxW-1:0] REG_INPUT    = 2'd0;
    localparam logic [RegIdxW-1:0] REG_OUTPUT   = 2'd1;
    localparam logic [RegIdxW-1:0] REG_POLARITY = 2'd2;
    localparam logic [RegIdxW-1:0] REG_DIRECT   = 2'd3;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'b01,
        ST_FULL  = 2'b10
    } t_ctl_state;

    typedef struct packed {
        logic load;
    } t_gpx_cmd;

endpackage

`default_nettype wire

[design/gpx_ctrl.sv]
// Controller for the GPIO expander register block: tracks the result
// register and issues the load command. Depends on gpx_pkg.
`default_nettype none

module gpx_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_out_stall,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output gpx_pkg::t_gpx_cmd  o_cmd
);

    gpx_pkg::t_ctl_state r_state;
    gpx_pkg::t_ctl_state n_state;
    logic                accept;

    assign o_out_valid = (r_state == gpx_pkg::ST_FULL);
    assign o_in_stall  = o_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cmd.load  = accept;

    always_comb begin
        n_state = r_state;
        case (r_state)
            gpx_pkg::ST_EMPTY: begin
                if (accept) begin
                    n_state = gpx_pkg::ST_FULL;
                end
            end
            gpx_pkg::ST_FULL: begin
                if (!i_out_stall && !accept) begin
                    n_state = gpx_pkg::ST_EMPTY;
                end
            end
            default: begin
                n_state = gpx_pkg::ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gpx_pkg::ST_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[design/gpx_dp.sv]
// Datapath for the GPIO expander register block: pointer, port registers
// and the result register. Depends on gpx_pkg.
`default_nettype none

module gpx_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire gpx_pkg::t_gpx_cmd             i_cmd,
    input  wire logic [gpx_pkg::ModeW-1:0]     i_mode,
    input  wire logic [gpx_pkg::ByteW-1:0]     i_byte_value,
    input  wire logic [gpx_pkg::PinIdxW-1:0]   i_pin_index,
    input  wire logic                          i_pin_level,
    output logic [gpx_pkg::ByteW-1:0]          o_read_byte,
    output logic                               o_nak,
    output logic [gpx_pkg::ByteW-1:0]          o_drive_changed,
    output logic [gpx_pkg::ByteW-1:0]          o_drive_levels
);

    logic [gpx_pkg::ByteW-1:0]   r_pointer, n_pointer;
    logic                        r_phase, n_phase;
    logic [gpx_pkg::ByteW-1:0]   r_in_port, n_in_port;
    logic [gpx_pkg::ByteW-1:0]   r_out_port, n_out_port;
    logic [gpx_pkg::ByteW-1:0]   r_polarity, n_polarity;
    logic [gpx_pkg::ByteW-1:0]   r_direct, n_direct;
    logic [gpx_pkg::ByteW-1:0]   r_read_byte, n_read_byte;
    logic                        r_nak, n_nak;
    logic [gpx_pkg::ByteW-1:0]   r_changed, n_changed;
    logic [gpx_pkg::ByteW-1:0]   r_levels;
    logic                        ptr_valid;
    logic [gpx_pkg::RegIdxW-1:0] reg_idx;
    logic [gpx_pkg::ByteW-1:0]   pin_bit;

    assign ptr_valid = (r_pointer[gpx_pkg::ByteW-1:gpx_pkg::RegIdxW] == '0);
    assign reg_idx   = r_pointer[gpx_pkg::RegIdxW-1:0];
    assign pin_bit   = gpx_pkg::ByteW'(1) << i_pin_index;

    always_comb begin
        n_pointer   = r_pointer;
        n_phase     = r_phase;
        n_in_port   = r_in_port;
        n_out_port  = r_out_port;
        n_polarity  = r_polarity;
        n_direct    = r_direct;
        n_read_byte = '0;
        n_nak       = 1'b0;
        n_changed   = '0;
        case (i_mode)
            gpx_pkg::MODE_WR_START: begin
                n_phase = 1'b0;
            end
            gpx_pkg::MODE_WR_BYTE: begin
                if (!r_phase) begin
                    n_pointer = i_byte_value;
                    n_phase   = 1'b1;
                end else if (!ptr_valid) begin
                    n_nak = 1'b1;
                end else begin
                    case (reg_idx)
                        gpx_pkg::REG_OUTPUT: begin
                            n_changed  = (r_out_port ^ i_byte_value) & ~r_direct;
                            n_out_port = i_byte_value;
                        end
                        gpx_pkg::REG_POLARITY: n_polarity = i_byte_value;
                        gpx_pkg::REG_DIRECT:   n_direct   = i_byte_value;
                        default: ;
                    endcase
                    n_pointer = r_pointer + gpx_pkg::ByteW'(1);
                end
            end
            gpx_pkg::MODE_RD_REQ: begin
                if (ptr_valid) begin
                    case (reg_idx)
                        gpx_pkg::REG_INPUT:    n_read_byte = r_in_port ^ r_polarity;
                        gpx_pkg::REG_OUTPUT:   n_read_byte = r_out_port;
                        gpx_pkg::REG_POLARITY: n_read_byte = r_polarity;
                        default:               n_read_byte = r_direct;
                    endcase
                    n_pointer = r_pointer + gpx_pkg::ByteW'(1);
                end
            end
            default: begin
                if (i_pin_level) begin
                    n_in_port = r_in_port | pin_bit;
                end else begin
                    n_in_port = r_in_port & ~pin_bit;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pointer  <= '0;
            r_phase    <= 1'b0;
            r_in_port  <= '0;
            r_out_port <= '0;
            r_polarity <= '0;
            r_direct   <= '0;
        end else if (i_cmd.load) begin
            r_pointer  <= n_pointer;
            r_phase    <= n_phase;
            r_in_port  <= n_in_port;
            r_out_port <= n_out_port;
            r_polarity <= n_polarity;
            r_direct   <= n_direct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_read_byte <= n_read_byte;
            r_nak       <= n_nak;
            r_changed   <= n_changed;
            r_levels    <= n_out_port;
        end
    end

    assign o_read_byte     = r_read_byte;
    assign o_nak           = r_nak;
    assign o_drive_changed = r_changed;
    assign o_drive_levels  = r_levels;

endmodule

`default_nettype wire

[design/i2c_gpio_expander_regs.sv]
// Top level of the GPIO expander register block: controller plus datapath.
// Depends on gpx_pkg, gpx_ctrl and gpx_dp.
//
//   Channel | Handshake                | Payload
//   in      | i_in_valid / o_in_stall  | i_mode, i_byte_value, i_pin_index, i_pin_level
//   out     | o_out_valid / i_out_stall| o_read_byte, o_nak, o_drive_changed, o_drive_levels
//
// The result of an accepted request appears in the result register on the
// next cycle. A new request is taken in the same cycle the result leaves,
// so the block sustains one request per cycle while the output is not stalled.
// Reset clears the state registers and empties the result register.
// A stalled result holds the input side only while the result register is full.
`default_nettype none

module i2c_gpio_expander_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [gpx_pkg::ModeW-1:0]   i_mode,
    input  wire logic [gpx_pkg::ByteW-1:0]   i_byte_value,
    input  wire logic [gpx_pkg::PinIdxW-1:0] i_pin_index,
    input  wire logic                        i_pin_level,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [gpx_pkg::ByteW-1:0]        o_read_byte,
    output logic                             o_nak,
    output logic [gpx_pkg::ByteW-1:0]        o_drive_changed,
    output logic [gpx_pkg::ByteW-1:0]        o_drive_levels
);

    gpx_pkg::t_gpx_cmd cmd;

    gpx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    gpx_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_mode          (i_mode),
        .i_byte_value    (i_byte_value),
        .i_pin_index     (i_pin_index),
        .i_pin_level     (i_pin_level),
        .o_read_byte     (o_read_byte),
        .o_nak           (o_nak),
        .o_drive_changed (o_drive_changed),
        .o_drive_levels  (o_drive_levels)
    );

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted request produced no result");

    a_empty_never_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

    a_nak_is_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_nak) |-> (o_read_byte == '0 && o_drive_changed == '0))
        else $error("NAK result carries read data or pin changes");

    a_change_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_drive_changed != '0) |-> (o_read_byte == '0))
        else $error("pin change reported together with read data");

endmodule

`default_nettype wire
